// File: rtl/qsbr_pkg.sv
// Shared types and constants for the QUIC spin bit rewriter.
package qsbr_pkg;

   localparam int PATTERN_BITS_DEF = 64;
   localparam int LFSR_WIDTH_DEF   = 32;
   localparam logic [63:0] LFSR_TAPS_DEF = 64'h0000_0000_8020_0003;
   localparam logic [63:0] LFSR_SEED     = 64'h0000_0000_ACE1_ACE1;

   // Pattern length in bits, up to eight bytes
   localparam int PAT_LEN_W = 7;

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;

   localparam logic REQ_PACKET = 1'b0;
   localparam logic REQ_TICK   = 1'b1;

   localparam logic [15:0] MIN_PACKET_LEN = 16'd5;
   localparam int          LONG_HDR_BIT   = 7;
   localparam int          SPIN_BIT_POS   = 5;
   localparam logic [9:0]  LAST_US_OF_MS  = 10'd999;
   localparam logic [9:0]  HALF_MS_US     = 10'd500;
   localparam logic [3:0]  MAX_PAT_BYTES  = 4'd8;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_ENABLE         = 3'd0,
      REG_STRATEGY       = 3'd1,
      REG_FLIP_THRESHOLD = 3'd2,
      REG_INTERVAL_MS    = 3'd3,
      REG_PATTERN_BYTES  = 3'd4,
      REG_PATTERN_WORD   = 3'd5
   } csr_reg_type;

   typedef enum logic [2:0] {
      STRAT_RANDOM      = 3'd0,
      STRAT_ALTERNATING = 3'd1,
      STRAT_ZERO        = 3'd2,
      STRAT_ONE         = 3'd3,
      STRAT_TIMING      = 3'd4,
      STRAT_MIMICRY     = 3'd5
   } strategy_type;

   // Status from the time base to the bit picker
   typedef struct packed {
      logic parity;      // interval parity
      logic early_half;  // microsecond count below 500
   } timebase_type;

endpackage

// File: rtl/qsbr_timebase.sv
// Microsecond, millisecond and interval parity counters driven by tick items.
module qsbr_timebase (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 tick,
   input  logic                 restart,
   input  logic [15:0]          interval_ms,
   output qsbr_pkg::timebase_type status
);
   import qsbr_pkg::*;

   logic [9:0]  micro_ff, micro_in;
   logic [15:0] milli_ff, milli_in;
   logic        parity_ff, parity_in;
   logic [15:0] ivl;
   logic [15:0] milli_inc;

   always_comb begin
      ivl       = (interval_ms == 16'd0) ? 16'd1 : interval_ms;
      milli_inc = milli_ff + 16'd1;
      micro_in  = micro_ff;
      milli_in  = milli_ff;
      parity_in = parity_ff;
      if (restart) begin
         micro_in  = '0;
         milli_in  = '0;
         parity_in = 1'b0;
      end else if (tick) begin
         if (micro_ff >= LAST_US_OF_MS) begin
            micro_in = '0;
            if (milli_inc >= ivl) begin
               milli_in  = '0;
               parity_in = ~parity_ff;
            end else begin
               milli_in = milli_inc;
            end
         end else begin
            micro_in = micro_ff + 10'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         micro_ff  <= '0;
         milli_ff  <= '0;
         parity_ff <= 1'b0;
      end else begin
         micro_ff  <= micro_in;
         milli_ff  <= milli_in;
         parity_ff <= parity_in;
      end
   end

   assign status.parity     = parity_ff;
   assign status.early_half = (micro_ff < HALF_MS_US);

endmodule

// File: rtl/quic_spin_bit_rewriter_top.sv
// Top level of the QUIC spin bit rewriter: config registers, bit picker, result register.
//
// Usage:
//   req channel carries packet items (tuser = 0) and one-microsecond ticks
//   (tuser = 1). Ticks only advance the time base and give no result.
//   Each packet gives exactly one rsp transfer with the first header byte,
//   possibly with its spin bit (0x20) rewritten when the header is short.
//   csr channel writes one register per transfer (index 0..5); every such write
//   restarts the time counters and the mimicry pattern position. Indexes
//   6 and 7 are ignored. csr_ready is always high.
// Latency: a packet result is valid in the cycle after its req transfer.
// Throughput: one item per cycle while req_tready is high; all state updates
//   for an item are done in the cycle it is taken, so items follow back to back.
// Stall: the result register holds while rsp_tready is low; req_tready
//   drops only while a result is held and not being taken.
// Reset: registers return to their defaults (enable off, random strategy,
//   threshold 32768, interval 100 ms, empty pattern), the LFSR to its seed,
//   counters to zero, and no result pending.
module quic_spin_bit_rewriter_top #(
   parameter int                PATTERN_BITS = qsbr_pkg::PATTERN_BITS_DEF,
   parameter int                LFSR_WIDTH   = qsbr_pkg::LFSR_WIDTH_DEF,
   parameter logic [63:0]       LFSR_TAPS    = qsbr_pkg::LFSR_TAPS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // req_tdata: first_byte[7:0], packet_length[23:8], orig_spin[24], zero[31:25]
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [qsbr_pkg::REQ_DATA_W-1:0]   req_tdata,
   // req_tuser: req_type[0]
   input  logic [0:0]                        req_tuser,
   // rsp_tdata: out_byte[7:0], spin_bit[8], rewritten[9], zero[15:10]
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [qsbr_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [qsbr_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [qsbr_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import qsbr_pkg::*;

   localparam int POS_W = $clog2(PATTERN_BITS);
   localparam logic [LFSR_WIDTH-1:0] TAP_MASK  = LFSR_TAPS[LFSR_WIDTH-1:0];
   localparam logic [LFSR_WIDTH-1:0] SEED_MASK = LFSR_SEED[LFSR_WIDTH-1:0];

   // Configuration registers
   logic                    enable_ff;
   logic [2:0]              strategy_ff;
   logic [16:0]             threshold_ff;
   logic [15:0]             interval_ff;
   logic [3:0]              pat_bytes_ff;
   logic [PATTERN_BITS-1:0] pattern_ff;

   logic [LFSR_WIDTH-1:0]   lfsr_ff, lfsr_in;
   logic [POS_W-1:0]        pos_ff, pos_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [7:0]              out_byte_ff, out_byte_in;
   logic                    spin_ff, spin_in;
   logic                    rewritten_ff, rewritten_in;

   logic        req_xfer, is_tick, pkt_xfer, csr_xfer, restart, active;
   logic [7:0]  first_byte;
   logic [15:0] packet_length;
   logic        orig_spin;
   logic        new_bit, lfsr_adv, pos_adv;
   logic [15:0] lfsr_upper;
   logic [3:0]  nbytes;
   logic [PAT_LEN_W-1:0] pat_len, raw_len, pos_ext, pos_inc;
   logic [POS_W-1:0]     pos_sel, pos_next;
   logic [LFSR_WIDTH-1:0] lfsr_shift;
   timebase_type tb_status;

   assign first_byte    = req_tdata[7:0];
   assign packet_length = req_tdata[23:8];
   assign orig_spin     = req_tdata[24];

   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign csr_ready  = 1'b1;
   assign req_xfer   = req_tvalid & req_tready;
   assign is_tick    = (req_tuser[0] == REQ_TICK);
   assign pkt_xfer   = req_xfer & ~is_tick;
   assign csr_xfer   = csr_valid & csr_ready;
   // Writes beyond the register list leave everything alone
   assign restart    = csr_xfer & (csr_index <= REG_PATTERN_WORD);
   assign active     = enable_ff & (packet_length >= MIN_PACKET_LEN);

   qsbr_timebase u_timebase (
      .clock       (clock),
      .reset       (reset),
      .tick        (req_xfer & is_tick),
      .restart     (restart),
      .interval_ms (interval_ff),
      .status      (tb_status)
   );

   // Galois step, right shift
   assign lfsr_shift = lfsr_ff >> 1;
   assign lfsr_upper = lfsr_ff[LFSR_WIDTH-1 -: 16];

   // Mimicry pattern length and position
   always_comb begin
      nbytes  = (pat_bytes_ff > MAX_PAT_BYTES) ? MAX_PAT_BYTES : pat_bytes_ff;
      raw_len = {nbytes[PAT_LEN_W-4:0], 3'b000};
      pat_len = (raw_len > PAT_LEN_W'(PATTERN_BITS)) ? PAT_LEN_W'(PATTERN_BITS) : raw_len;
      pos_ext = PAT_LEN_W'(pos_ff);
      pos_sel = (pos_ext < pat_len) ? pos_ff : '0;
      pos_inc = PAT_LEN_W'(pos_sel) + PAT_LEN_W'(1);
      pos_next = (pos_inc >= pat_len) ? '0 : POS_W'(pos_inc);
   end

   always_comb begin
      new_bit  = orig_spin;
      lfsr_adv = 1'b0;
      pos_adv  = 1'b0;
      case (strategy_type'(strategy_ff))
         STRAT_RANDOM: begin
            lfsr_adv = 1'b1;
            new_bit  = ({1'b0, lfsr_upper} < threshold_ff) ? ~orig_spin : orig_spin;
         end
         STRAT_ALTERNATING: new_bit = tb_status.parity;
         STRAT_ZERO:        new_bit = 1'b0;
         STRAT_ONE:         new_bit = 1'b1;
         STRAT_TIMING:      new_bit = tb_status.early_half ^ orig_spin;
         STRAT_MIMICRY: begin
            if (pat_len != '0) begin
               pos_adv = 1'b1;
               new_bit = pattern_ff[pos_sel];
            end
         end
         default: new_bit = orig_spin;
      endcase
   end

   always_comb begin
      lfsr_in = lfsr_ff;
      pos_in  = pos_ff;
      if (pkt_xfer && active && lfsr_adv) begin
         lfsr_in = lfsr_ff[0] ? (lfsr_shift ^ TAP_MASK) : lfsr_shift;
      end
      if (restart) begin
         pos_in = '0;
      end else if (pkt_xfer && active && pos_adv) begin
         pos_in = pos_next;
      end
   end

   // Result register; holds while the receiver stalls
   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      out_byte_in  = out_byte_ff;
      spin_in      = spin_ff;
      rewritten_in = rewritten_ff;
      if (pkt_xfer) begin
         rsp_valid_in = 1'b1;
         out_byte_in  = first_byte;
         spin_in      = orig_spin;
         rewritten_in = 1'b0;
         if (active && !first_byte[LONG_HDR_BIT]) begin
            out_byte_in[SPIN_BIT_POS] = new_bit;
            spin_in      = new_bit;
            rewritten_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b0;
         strategy_ff  <= STRAT_RANDOM;
         threshold_ff <= 17'd32768;
         interval_ff  <= 16'd100;
         pat_bytes_ff <= '0;
         pattern_ff   <= '0;
      end else if (csr_xfer) begin
         case (csr_reg_type'(csr_index))
            REG_ENABLE:         enable_ff    <= csr_wdata[0];
            REG_STRATEGY:       strategy_ff  <= csr_wdata[2:0];
            REG_FLIP_THRESHOLD: threshold_ff <= csr_wdata[16:0];
            REG_INTERVAL_MS:    interval_ff  <= csr_wdata[15:0];
            REG_PATTERN_BYTES:  pat_bytes_ff <= csr_wdata[3:0];
            REG_PATTERN_WORD:   pattern_ff   <= csr_wdata[PATTERN_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lfsr_ff      <= SEED_MASK;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         lfsr_ff      <= lfsr_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff  <= out_byte_in;
      spin_ff      <= spin_in;
      rewritten_ff <= rewritten_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rewritten_ff, spin_ff, out_byte_ff};

endmodule

// File: dv/quic_spin_bit_rewriter_top_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the QUIC spin bit rewriter top level.
module quic_spin_bit_rewriter_top_test;
   import qsbr_pkg::*;

   localparam logic [2:0] IDX_SPARE_LO   = 3'd6;
   localparam logic [2:0] IDX_SPARE_HI   = 3'd7;
   localparam logic [2:0] STRAT_SPARE_LO = 3'd6;
   localparam logic [2:0] STRAT_SPARE_HI = 3'd7;
   localparam int US_PER_MS     = 1000;
   localparam int BITS_PER_BYTE = 8;
   localparam int IDLE_PCT      = 16;
   localparam int RANDOM_STEPS  = 850;
   localparam int PHASE_STEPS   = 85;

   typedef struct packed {
      logic [7:0] hdr;
      logic       spin;
      logic       rewritten;
   } hdr_result_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;
   logic [0:0]             req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   // shadow copy of the block's registers and state
   logic                      cfg_enable;
   logic [2:0]                cfg_strategy;
   logic [16:0]               cfg_flip_thr;
   logic [15:0]               cfg_interval;
   logic [3:0]                cfg_pat_bytes;
   logic [63:0]               cfg_pat_word;
   logic [LFSR_WIDTH_DEF-1:0] lfsr_st;
   int                        us_count;
   int                        ms_count;
   logic                      parity_st;
   int                        pat_idx;

   hdr_result_type hdr_result_q[$];
   bit          quiet         = 1'b0;
   int          fail_count    = 0;
   int          checked_count = 0;
   int          pkt_count     = 0;
   int          tick_count    = 0;
   int          csr_count     = 0;

   quic_spin_bit_rewriter_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
   end

   // rsp_tdata: out_byte[7:0], spin_bit[8], rewritten[9]
   always @(posedge clock) begin : rsp_check
      hdr_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (hdr_result_q.size() == 0) begin
            $error("unexpected result transfer: tdata %h", rsp_tdata);
            fail_count++;
         end else begin
            want = hdr_result_q.pop_front();
            checked_count++;
            if (rsp_tdata[7:0] !== want.hdr) begin
               $error("out_byte: expected %h, actual %h", want.hdr, rsp_tdata[7:0]);
               fail_count++;
            end
            if (rsp_tdata[8] !== want.spin) begin
               $error("spin_bit: expected %b, actual %b", want.spin, rsp_tdata[8]);
               fail_count++;
            end
            if (rsp_tdata[9] !== want.rewritten) begin
               $error("rewritten: expected %b, actual %b", want.rewritten, rsp_tdata[9]);
               fail_count++;
            end
         end
      end
   end

   task automatic restart_timebase();
      us_count  = 0;
      ms_count  = 0;
      parity_st = 1'b0;
      pat_idx   = 0;
   endtask

   task automatic predict_header_rewrite(logic kind, logic [7:0] hdr, logic [15:0] len,
                                         logic orig);
      hdr_result_type res;
      logic        nb;
      logic [15:0] upper;
      int          ivl;
      int          plen;
      int          pos;
      if (kind == REQ_TICK) begin
         ivl = (cfg_interval == 0) ? 1 : int'(cfg_interval);
         us_count++;
         if (us_count >= US_PER_MS) begin
            us_count = 0;
            ms_count = (ms_count + 1) & 16'hFFFF;
            if (ms_count >= ivl) begin
               ms_count  = 0;
               parity_st = ~parity_st;
            end
         end
      end else begin
         res.hdr       = hdr;
         res.spin      = orig;
         res.rewritten = 1'b0;
         if (cfg_enable && len >= MIN_PACKET_LEN) begin
            nb = orig;
            case (cfg_strategy)
               STRAT_RANDOM: begin
                  // compare on the current value, then step the Galois LFSR
                  upper = lfsr_st[LFSR_WIDTH_DEF-1 -: 16];
                  if (lfsr_st[0])
                     lfsr_st = (lfsr_st >> 1) ^ LFSR_TAPS_DEF[LFSR_WIDTH_DEF-1:0];
                  else
                     lfsr_st = lfsr_st >> 1;
                  nb = ({1'b0, upper} < cfg_flip_thr) ? ~orig : orig;
               end
               STRAT_ALTERNATING: nb = parity_st;
               STRAT_ZERO:        nb = 1'b0;
               STRAT_ONE:         nb = 1'b1;
               STRAT_TIMING:      nb = (us_count < HALF_MS_US) ^ orig;
               STRAT_MIMICRY: begin
                  plen = ((cfg_pat_bytes > MAX_PAT_BYTES) ? MAX_PAT_BYTES : cfg_pat_bytes)
                         * BITS_PER_BYTE;
                  if (plen > PATTERN_BITS_DEF) plen = PATTERN_BITS_DEF;
                  if (plen != 0) begin
                     pos     = (pat_idx < plen) ? pat_idx : 0;
                     nb      = cfg_pat_word[pos];
                     pat_idx = (pos + 1 >= plen) ? 0 : pos + 1;
                  end
               end
               default: nb = orig;
            endcase
            // long headers keep their byte even though the strategy ran
            if (!hdr[LONG_HDR_BIT]) begin
               res.hdr[SPIN_BIT_POS] = nb;
               res.spin              = nb;
               res.rewritten         = 1'b1;
            end
         end
         hdr_result_q.push_back(res);
      end
   endtask

   task automatic send_item(logic kind, logic [7:0] hdr, logic [15:0] len, logic orig);
      while (!quiet && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {7'd0, orig, len, hdr};
      do @(posedge clock); while (!req_tready);
      predict_header_rewrite(kind, hdr, len, orig);
      if (kind == REQ_TICK) tick_count++;
      else pkt_count++;
   endtask

   task automatic send_ticks(int n);
      repeat (n) send_item(REQ_TICK, 8'($urandom), 16'($urandom), 1'($urandom));
   endtask

   // stop sending and let every outstanding result come back
   task automatic settle();
      int guard;
      req_tvalid <= 1'b0;
      guard = 0;
      while (hdr_result_q.size() != 0 && guard < 2000) begin
         @(posedge clock);
         guard++;
      end
      if (hdr_result_q.size() != 0) begin
         $error("%0d expected results never arrived", hdr_result_q.size());
         fail_count++;
         hdr_result_q.delete();
      end
      repeat (3) @(posedge clock);
   endtask

   task automatic write_csr(logic [2:0] idx, logic [63:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      csr_count++;
      case (idx)
         REG_ENABLE:         cfg_enable    = data[0];
         REG_STRATEGY:       cfg_strategy  = data[2:0];
         REG_FLIP_THRESHOLD: cfg_flip_thr  = data[16:0];
         REG_INTERVAL_MS:    cfg_interval  = data[15:0];
         REG_PATTERN_BYTES:  cfg_pat_bytes = data[3:0];
         REG_PATTERN_WORD:   cfg_pat_word  = data;
         default: ;
      endcase
      // spare indexes leave the time base running
      if (idx <= REG_PATTERN_WORD) restart_timebase();
      @(posedge clock);
   endtask

   task automatic test_reset_passthrough();
      send_item(REQ_PACKET, 8'h00, 16'd0, 1'b0);
      send_item(REQ_PACKET, 8'hFF, 16'hFFFF, 1'b1);
      send_item(REQ_PACKET, 8'h20, 16'd5, 1'b0);
      send_item(REQ_TICK, 8'hFF, 16'hFFFF, 1'b1);
      send_item(REQ_PACKET, 8'h5F, 16'd4, 1'b1);
      settle();
   endtask

   task automatic test_random_flip();
      write_csr(REG_ENABLE, 64'd1);
      repeat (4) send_item(REQ_PACKET, 8'h41, 16'd1200, 1'b0);
      send_item(REQ_PACKET, 8'h61, 16'd4, 1'b1);   // too short: LFSR holds
      send_item(REQ_PACKET, 8'hC3, 16'd64, 1'b1);  // long header: LFSR still steps
      send_item(REQ_PACKET, 8'h1E, 16'd5, 1'b1);
      settle();
      write_csr(REG_FLIP_THRESHOLD, 64'd0);
      repeat (2) send_item(REQ_PACKET, 8'h00, 16'd100, 1'b1);
      settle();
      write_csr(REG_FLIP_THRESHOLD, 64'd65536);
      repeat (2) send_item(REQ_PACKET, 8'h7F, 16'd100, 1'b0);
      settle();
      write_csr(REG_FLIP_THRESHOLD, 64'hFFFF_FFFF_FFFF_FFFF);
      repeat (2) send_item(REQ_PACKET, 8'h20, 16'd100, 1'b1);
      settle();
   endtask

   task automatic test_fixed_strategies();
      logic [2:0] codes [4];
      codes = '{STRAT_ZERO, STRAT_ONE, STRAT_SPARE_LO, STRAT_SPARE_HI};
      foreach (codes[k]) begin
         write_csr(REG_STRATEGY, {61'd0, codes[k]});
         send_item(REQ_PACKET, 8'h00, 16'd9, 1'b1);
         send_item(REQ_PACKET, 8'h3F, 16'd9, 1'b0);
         send_item(REQ_PACKET, 8'hA0, 16'd9, 1'b1);
         settle();
      end
   endtask

   task automatic test_alternating_interval();
      write_csr(REG_STRATEGY, {61'd0, STRAT_ALTERNATING});
      write_csr(REG_INTERVAL_MS, 64'd0);   // zero interval behaves as one
      send_item(REQ_PACKET, 8'h20, 16'd50, 1'b1);
      send_ticks(US_PER_MS - 1);
      send_item(REQ_PACKET, 8'h20, 16'd50, 1'b1);
      send_ticks(1);
      send_item(REQ_PACKET, 8'h00, 16'd50, 1'b0);
      settle();
      write_csr(REG_INTERVAL_MS, 64'd2);
      send_ticks(US_PER_MS);
      send_item(REQ_PACKET, 8'h00, 16'd50, 1'b0);
      send_ticks(US_PER_MS);
      send_item(REQ_PACKET, 8'h00, 16'd50, 1'b0);
      settle();
      write_csr(REG_INTERVAL_MS, 64'd65535);
      send_ticks(US_PER_MS);
      send_item(REQ_PACKET, 8'h20, 16'd50, 1'b0);
      settle();
   endtask

   task automatic test_timing_half();
      write_csr(REG_STRATEGY, {61'd0, STRAT_TIMING});
      send_item(REQ_PACKET, 8'h00, 16'd30, 1'b0);
      send_ticks(HALF_MS_US - 1);
      send_item(REQ_PACKET, 8'h00, 16'd30, 1'b1);
      send_ticks(1);
      send_item(REQ_PACKET, 8'h20, 16'd30, 1'b0);
      settle();
      write_csr(IDX_SPARE_LO, {$urandom, $urandom});
      send_item(REQ_PACKET, 8'h20, 16'd30, 1'b1);
      settle();
      write_csr(IDX_SPARE_HI, {$urandom, $urandom});
      send_ticks(HALF_MS_US - 1);
      send_item(REQ_PACKET, 8'h80, 16'd30, 1'b1);
      send_ticks(1);
      send_item(REQ_PACKET, 8'h00, 16'd30, 1'b1);
      settle();
   endtask

   task automatic test_mimicry_pattern();
      write_csr(REG_STRATEGY, {61'd0, STRAT_MIMICRY});
      write_csr(REG_PATTERN_WORD, 64'hFFFF_FFFF_FFFF_FFFF);
      repeat (2) send_item(REQ_PACKET, 8'h00, 16'd10, 1'b0);  // empty pattern
      settle();
      write_csr(REG_PATTERN_WORD, 64'h0000_0000_0000_005A);
      write_csr(REG_PATTERN_BYTES, 64'd1);
      repeat (4) send_item(REQ_PACKET, 8'h11, 16'd10, 1'b1);
      send_item(REQ_PACKET, 8'hF1, 16'd10, 1'b1);  // long header still advances
      repeat (5) send_item(REQ_PACKET, 8'h11, 16'd10, 1'b0);
      settle();
      write_csr(REG_PATTERN_WORD, {$urandom, $urandom});
      write_csr(REG_PATTERN_BYTES, 64'd8);
      repeat (3) send_item(REQ_PACKET, 8'h2C, 16'd10, 1'b1);
      settle();
      write_csr(REG_PATTERN_BYTES, 64'hF);  // above eight acts as eight
      repeat (3) send_item(REQ_PACKET, 8'h2C, 16'd10, 1'b0);
      settle();
   endtask

   task automatic shuffle_config();
      logic [63:0] junk;
      logic [2:0]  strat;
      logic [16:0] thr;
      logic [15:0] ivl;
      logic [3:0]  pb;
      settle();
      junk = {$urandom, $urandom};
      // upper data bits carry junk to exercise the register masks
      if ($urandom_range(1))
         write_csr(REG_ENABLE, {junk[63:1], $urandom_range(99) < 85});
      if ($urandom_range(1)) begin
         strat = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
         write_csr(REG_STRATEGY, {junk[63:3], strat});
      end
      if ($urandom_range(1)) begin
         case ($urandom_range(4))
            0:       thr = 17'd0;
            1:       thr = 17'd65536;
            2:       thr = 17'h1FFFF;
            default: thr = 17'($urandom_range(65536));
         endcase
         write_csr(REG_FLIP_THRESHOLD, {junk[63:17], thr});
      end
      if ($urandom_range(1)) begin
         case ($urandom_range(5))
            0:       ivl = 16'd0;
            1:       ivl = 16'hFFFF;
            default: ivl = 16'($urandom_range(3, 1));
         endcase
         write_csr(REG_INTERVAL_MS, {junk[63:16], ivl});
      end
      if ($urandom_range(1)) begin
         pb = 4'($urandom_range(15));
         write_csr(REG_PATTERN_BYTES, {junk[63:4], pb});
      end
      if ($urandom_range(1)) begin
         case ($urandom_range(3))
            0:       write_csr(REG_PATTERN_WORD, 64'd0);
            1:       write_csr(REG_PATTERN_WORD, 64'hFFFF_FFFF_FFFF_FFFF);
            default: write_csr(REG_PATTERN_WORD, {$urandom, $urandom});
         endcase
      end
      if ($urandom_range(9) == 0)
         write_csr($urandom_range(1) ? IDX_SPARE_LO : IDX_SPARE_HI, {$urandom, $urandom});
   endtask

   task automatic test_random_traffic();
      int          step;
      int          pick;
      logic [7:0]  hdr;
      logic [15:0] len;
      for (step = 0; step < RANDOM_STEPS; step++) begin
         if (step % PHASE_STEPS == 0) shuffle_config();
         quiet = (step >= 340 && step < 510);
         pick  = $urandom_range(99);
         if (pick < 8 && (cfg_strategy == STRAT_ALTERNATING || cfg_strategy == STRAT_TIMING))
            send_ticks($urandom_range(1200, 1));
         else if (pick < 30)
            send_item(REQ_TICK, 8'($urandom), 16'($urandom), 1'($urandom));
         else begin
            hdr = 8'($urandom);
            len = 16'($urandom_range(1500, 5));
            if (pick < 85) begin
               hdr[LONG_HDR_BIT] = 1'b0;
            end else begin
               case ($urandom_range(3))
                  0:       len = 16'($urandom_range(4));
                  1:       len = 16'hFFFF;
                  default: len = 16'($urandom);
               endcase
            end
            send_item(REQ_PACKET, hdr, len, 1'($urandom_range(1)));
         end
      end
      quiet = 1'b0;
      settle();
   endtask

   initial begin
      cfg_enable    = 1'b0;
      cfg_strategy  = STRAT_RANDOM;
      cfg_flip_thr  = 17'd32768;
      cfg_interval  = 16'd100;
      cfg_pat_bytes = 4'd0;
      cfg_pat_word  = 64'd0;
      lfsr_st       = LFSR_SEED[LFSR_WIDTH_DEF-1:0];
      restart_timebase();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_reset_passthrough();
      test_random_flip();
      test_fixed_strategies();
      test_alternating_interval();
      test_timing_half();
      test_mimicry_pattern();
      test_random_traffic();
      repeat (4) @(posedge clock);
      $display("Checked %0d packet results against %0d packets; sent %0d ticks, %0d csr writes",
               checked_count, pkt_count, tick_count, csr_count);
      $display("Covered all strategies, undefined codes, masks, spare indexes and stalls");
      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// File: files.f
rtl/qsbr_pkg.sv
rtl/qsbr_timebase.sv
rtl/quic_spin_bit_rewriter_top.sv
dv/quic_spin_bit_rewriter_top_test.sv
